FILE: rtl/trsc_pkg.sv
// ----------------------------------------------------------------------------
// trsc_pkg
// types, register indexes and rotor wiring tables for the three-rotor cipher
// ----------------------------------------------------------------------------
package trsc_pkg;

	localparam int unsigned LETTER_W = 5;
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [LETTER_W-1:0] LAST_LETTER = 5'd25;
	localparam logic [LETTER_W:0] NUM_LETTERS = 6'd26;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_FAST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_SLOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd2;

	localparam logic DIR_ENCRYPT = 1'b0;

	typedef logic [LETTER_W-1:0] letter_t;

	// one letter in flight between the stepping stage and the mapping stage
	typedef struct packed {
		letter_t letter;
		logic    dir;
		letter_t fast_off;
		letter_t slow_off;
	} trsc_beat_t;

	// (a + b) mod 26 for a, b below 26
	function automatic letter_t add_mod26(input letter_t a, input letter_t b);
		logic [LETTER_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= NUM_LETTERS) begin
			s = s - NUM_LETTERS;
		end
		return s[LETTER_W-1:0];
	endfunction

	// (a - b) mod 26 for a, b below 26
	function automatic letter_t sub_mod26(input letter_t a, input letter_t b);
		logic [LETTER_W:0] s;
		s = {1'b0, a} + NUM_LETTERS - {1'b0, b};
		if (s >= NUM_LETTERS) begin
			s = s - NUM_LETTERS;
		end
		return s[LETTER_W-1:0];
	endfunction

	function automatic letter_t wiring_fast(input letter_t i);
		letter_t r;
		unique case (i)
			5'd0: r = 5'd12;   5'd1: r = 5'd22;   5'd2: r = 5'd25;   5'd3: r = 5'd11;
			5'd4: r = 5'd1;    5'd5: r = 5'd20;   5'd6: r = 5'd10;   5'd7: r = 5'd4;
			5'd8: r = 5'd19;   5'd9: r = 5'd18;   5'd10: r = 5'd2;   5'd11: r = 5'd14;
			5'd12: r = 5'd24;  5'd13: r = 5'd0;   5'd14: r = 5'd17;  5'd15: r = 5'd13;
			5'd16: r = 5'd7;   5'd17: r = 5'd3;   5'd18: r = 5'd21;  5'd19: r = 5'd15;
			5'd20: r = 5'd23;  5'd21: r = 5'd16;  5'd22: r = 5'd5;   5'd23: r = 5'd8;
			5'd24: r = 5'd9;   5'd25: r = 5'd6;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic letter_t wiring_slow(input letter_t i);
		letter_t r;
		unique case (i)
			5'd0: r = 5'd16;   5'd1: r = 5'd22;   5'd2: r = 5'd4;    5'd3: r = 5'd17;
			5'd4: r = 5'd19;   5'd5: r = 5'd24;   5'd6: r = 5'd20;   5'd7: r = 5'd8;
			5'd8: r = 5'd14;   5'd9: r = 5'd15;   5'd10: r = 5'd0;   5'd11: r = 5'd18;
			5'd12: r = 5'd3;   5'd13: r = 5'd5;   5'd14: r = 5'd6;   5'd15: r = 5'd7;
			5'd16: r = 5'd9;   5'd17: r = 5'd10;  5'd18: r = 5'd11;  5'd19: r = 5'd25;
			5'd20: r = 5'd23;  5'd21: r = 5'd2;   5'd22: r = 5'd21;  5'd23: r = 5'd1;
			5'd24: r = 5'd13;  5'd25: r = 5'd12;
			default: r = '0;
		endcase
		return r;
	endfunction

	// position of a letter in the fast wiring, 0 for codes above 25
	function automatic letter_t pos_fast(input letter_t v);
		letter_t r;
		unique case (v)
			5'd0: r = 5'd13;   5'd1: r = 5'd4;    5'd2: r = 5'd10;   5'd3: r = 5'd17;
			5'd4: r = 5'd7;    5'd5: r = 5'd22;   5'd6: r = 5'd25;   5'd7: r = 5'd16;
			5'd8: r = 5'd23;   5'd9: r = 5'd24;   5'd10: r = 5'd6;   5'd11: r = 5'd3;
			5'd12: r = 5'd0;   5'd13: r = 5'd15;  5'd14: r = 5'd11;  5'd15: r = 5'd19;
			5'd16: r = 5'd21;  5'd17: r = 5'd14;  5'd18: r = 5'd9;   5'd19: r = 5'd8;
			5'd20: r = 5'd5;   5'd21: r = 5'd18;  5'd22: r = 5'd1;   5'd23: r = 5'd20;
			5'd24: r = 5'd12;  5'd25: r = 5'd2;
			default: r = '0;
		endcase
		return r;
	endfunction

	// position of a letter in the slow wiring, 0 for codes above 25
	function automatic letter_t pos_slow(input letter_t v);
		letter_t r;
		unique case (v)
			5'd0: r = 5'd10;   5'd1: r = 5'd23;   5'd2: r = 5'd21;   5'd3: r = 5'd12;
			5'd4: r = 5'd2;    5'd5: r = 5'd13;   5'd6: r = 5'd14;   5'd7: r = 5'd15;
			5'd8: r = 5'd7;    5'd9: r = 5'd16;   5'd10: r = 5'd17;  5'd11: r = 5'd18;
			5'd12: r = 5'd25;  5'd13: r = 5'd24;  5'd14: r = 5'd8;   5'd15: r = 5'd9;
			5'd16: r = 5'd0;   5'd17: r = 5'd3;   5'd18: r = 5'd11;  5'd19: r = 5'd4;
			5'd20: r = 5'd6;   5'd21: r = 5'd22;  5'd22: r = 5'd1;   5'd23: r = 5'd20;
			5'd24: r = 5'd5;   5'd25: r = 5'd19;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/three_rotor_substitution_cipher.sv
// ----------------------------------------------------------------------------
// three_rotor_substitution_cipher
// letter stream cipher with a fast and a slow fixed-wiring rotor
//
//   channel  | signals                      | beat
//   ---------+------------------------------+----------------------------------
//   cfg      | cfg_valid/ready/index/data   | register write, ready always high
//   s_axis   | s_tvalid/tready/tdata/tuser  | one letter, tuser restarts message
//   m_axis   | m_tvalid/tready/tdata        | one transformed letter
//
// one letter per cycle unless a stall on m_axis holds the stages; a result passes
// through the stepping register and then the result register
// reset clears keys, direction, rotor offsets and turn counters
// a stall on m_axis holds both stages; s_tready drops only when both are full
// ----------------------------------------------------------------------------
module three_rotor_substitution_cipher (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [trsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [trsc_pkg::LETTER_W-1:0]  cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // letter_in [4:0], zero pad
	input  logic                           s_tuser,   // restart
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata    // letter_out [4:0], zero pad
);
	import trsc_pkg::*;

	logic       beat_valid;
	logic       beat_ready;
	trsc_beat_t beat;
	letter_t    out_letter;

	assign cfg_ready = 1'b1;

	trsc_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_letter  (s_tdata[LETTER_W-1:0]),
		.in_restart (s_tuser),
		.beat_valid (beat_valid),
		.beat_ready (beat_ready),
		.beat       (beat)
	);

	trsc_map u_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_valid (beat_valid),
		.beat_ready (beat_ready),
		.beat       (beat),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_letter (out_letter)
	);

	assign m_tdata = {3'b000, out_letter};

endmodule

FILE: rtl/trsc_step.sv
// ----------------------------------------------------------------------------
// trsc_step
// key registers, rotor offsets and turn counters; registers each accepted beat
// ----------------------------------------------------------------------------
module trsc_step (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [trsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [trsc_pkg::LETTER_W-1:0]    cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  trsc_pkg::letter_t                in_letter,
	input  logic                             in_restart,
	output logic                             beat_valid,
	input  logic                             beat_ready,
	output trsc_pkg::trsc_beat_t             beat
);
	import trsc_pkg::*;

	letter_t    key_fast_q;
	letter_t    key_slow_q;
	logic       dir_q;
	letter_t    fast_off_q;
	letter_t    slow_off_q;
	letter_t    fast_cnt_q;
	letter_t    mid_cnt_q;
	logic       valid_s1;
	trsc_beat_t beat_s1;

	letter_t fast_off_cur;
	letter_t slow_off_cur;
	letter_t fast_cnt_cur;
	letter_t mid_cnt_cur;
	logic    accept;

	assign in_ready = !valid_s1 || beat_ready;
	assign accept = in_valid && in_ready;

	// restart reloads offsets from keys and clears turn counters before this letter
	always_comb begin
		if (in_restart) begin
			fast_off_cur = pos_fast(key_fast_q);
			slow_off_cur = pos_slow(key_slow_q);
			fast_cnt_cur = '0;
			mid_cnt_cur = '0;
		end else begin
			fast_off_cur = fast_off_q;
			slow_off_cur = slow_off_q;
			fast_cnt_cur = fast_cnt_q;
			mid_cnt_cur = mid_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_fast_q <= '0;
			key_slow_q <= '0;
			dir_q <= DIR_ENCRYPT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KEY_FAST: key_fast_q <= cfg_data;
				REG_KEY_SLOW: key_slow_q <= cfg_data;
				REG_DIRECTION: dir_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_off_q <= '0;
			slow_off_q <= '0;
			fast_cnt_q <= '0;
			mid_cnt_q <= '0;
		end else if (accept) begin
			fast_off_q <= add_mod26(fast_off_cur, 5'd1);
			if (fast_cnt_cur == LAST_LETTER) begin
				fast_cnt_q <= '0;
				if (mid_cnt_cur == LAST_LETTER) begin
					mid_cnt_q <= '0;
					slow_off_q <= add_mod26(slow_off_cur, 5'd1);
				end else begin
					mid_cnt_q <= mid_cnt_cur + 5'd1;
					slow_off_q <= slow_off_cur;
				end
			end else begin
				fast_cnt_q <= fast_cnt_cur + 5'd1;
				mid_cnt_q <= mid_cnt_cur;
				slow_off_q <= slow_off_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1.letter <= in_letter;
			beat_s1.dir <= dir_q;
			beat_s1.fast_off <= fast_off_cur;
			beat_s1.slow_off <= slow_off_cur;
		end
	end

	assign beat_valid = valid_s1;
	assign beat = beat_s1;

`ifndef SYNTHESIS
	a_counts_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fast_cnt_q <= LAST_LETTER && mid_cnt_q <= LAST_LETTER)
		else $error("turn counter out of range");

	a_offsets_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fast_off_q <= LAST_LETTER && slow_off_q <= LAST_LETTER)
		else $error("rotor offset out of range");

	a_fast_steps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !in_restart |=> fast_off_q == add_mod26($past(fast_off_q), 5'd1))
		else $error("fast rotor did not advance by one");

	a_slow_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !in_restart && fast_cnt_q != LAST_LETTER |=> $stable(slow_off_q))
		else $error("slow rotor moved off its turnover");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !beat_ready |=> valid_s1 && $stable(beat_s1))
		else $error("stalled stage changed");
`endif

endmodule

FILE: rtl/trsc_map.sv
// ----------------------------------------------------------------------------
// trsc_map
// substitutes one letter through the offset rotors into the result register
// ----------------------------------------------------------------------------
module trsc_map (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          beat_valid,
	output logic                          beat_ready,
	input  trsc_pkg::trsc_beat_t          beat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output trsc_pkg::letter_t             out_letter
);
	import trsc_pkg::*;

	logic    valid_s2;
	letter_t letter_s2;
	letter_t pos;
	letter_t mapped;

	always_comb begin
		if (beat.dir == DIR_ENCRYPT) begin
			pos = sub_mod26(pos_fast(beat.letter), beat.fast_off);
			mapped = wiring_slow(add_mod26(beat.slow_off, pos));
		end else begin
			pos = sub_mod26(pos_slow(beat.letter), beat.slow_off);
			mapped = wiring_fast(add_mod26(beat.fast_off, pos));
		end
		if (beat.letter > LAST_LETTER) begin
			mapped = '0;
		end
	end

	assign beat_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (beat_ready) begin
			valid_s2 <= beat_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (beat_valid && beat_ready) begin
			letter_s2 <= mapped;
		end
	end

	assign out_valid = valid_s2;
	assign out_letter = letter_s2;

`ifndef SYNTHESIS
	a_result_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> letter_s2 <= LAST_LETTER)
		else $error("result letter out of range");

	a_bad_letter_zero: assert property (@(posedge clk) disable iff (!arst_n)
		beat_valid && beat_ready && beat.letter > LAST_LETTER |=> letter_s2 == '0)
		else $error("out of range letter not mapped to zero");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2 && $stable(letter_s2))
		else $error("stalled result changed");
`endif

endmodule

FILE: tb/sv/three_rotor_substitution_cipher_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_rotor_substitution_cipher_checker
// watches the config, input and output channels of the rotor cipher, keeps
// its own rotor positions and turn counts, and compares every output beat
// with the letter it predicts
// ----------------------------------------------------------------------------
module three_rotor_substitution_cipher_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [trsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [trsc_pkg::LETTER_W-1:0]  cfg_data,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // letter_in [4:0], zero pad
	input  logic                           s_tuser,   // restart
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [7:0]                     m_tdata,   // letter_out [4:0], zero pad
	output int                             fail_count,
	output int                             pending
);

	import trsc_pkg::*;

	localparam letter_t FAST_WIRING [26] = '{
		5'd12, 5'd22, 5'd25, 5'd11, 5'd1,  5'd20, 5'd10, 5'd4,  5'd19,
		5'd18, 5'd2,  5'd14, 5'd24, 5'd0,  5'd17, 5'd13, 5'd7,  5'd3,
		5'd21, 5'd15, 5'd23, 5'd16, 5'd5,  5'd8,  5'd9,  5'd6
	};
	localparam letter_t SLOW_WIRING [26] = '{
		5'd16, 5'd22, 5'd4,  5'd17, 5'd19, 5'd24, 5'd20, 5'd8,  5'd14,
		5'd15, 5'd0,  5'd18, 5'd3,  5'd5,  5'd6,  5'd7,  5'd9,  5'd10,
		5'd11, 5'd25, 5'd23, 5'd2,  5'd21, 5'd1,  5'd13, 5'd12
	};

	letter_t     fast_key;
	letter_t     slow_key;
	logic        decrypt;
	letter_t     fast_shift;
	letter_t     slow_shift;
	int unsigned letters_since_turn;
	int unsigned middle_turns;
	letter_t     cipher_queue [$];
	letter_t     want;

	// 26 when the letter is not on the rotor
	function automatic int unsigned fast_place(input letter_t v);
		for (int unsigned i = 0; i < 26; i++) begin
			if (FAST_WIRING[i] == v) begin
				return i;
			end
		end
		return 26;
	endfunction

	function automatic int unsigned slow_place(input letter_t v);
		for (int unsigned i = 0; i < 26; i++) begin
			if (SLOW_WIRING[i] == v) begin
				return i;
			end
		end
		return 26;
	endfunction

	// maps one letter and steps the rotors
	function automatic letter_t cipher_letter(input letter_t letter, input logic restart);
		int unsigned p;
		letter_t     result;
		if (restart) begin
			p = fast_place(fast_key);
			fast_shift = (p < 26) ? letter_t'(p) : '0;
			p = slow_place(slow_key);
			slow_shift = (p < 26) ? letter_t'(p) : '0;
			letters_since_turn = 0;
			middle_turns = 0;
		end
		result = '0;
		if (letter <= LAST_LETTER) begin
			if (decrypt == DIR_ENCRYPT) begin
				p = (fast_place(letter) + 26 - fast_shift) % 26;
				result = SLOW_WIRING[(slow_shift + p) % 26];
			end else begin
				p = (slow_place(letter) + 26 - slow_shift) % 26;
				result = FAST_WIRING[(fast_shift + p) % 26];
			end
		end
		fast_shift = letter_t'((fast_shift + 1) % 26);
		letters_since_turn++;
		if (letters_since_turn >= 26) begin
			letters_since_turn = 0;
			middle_turns++;
			if (middle_turns >= 26) begin
				middle_turns = 0;
				slow_shift = letter_t'((slow_shift + 1) % 26);
			end
		end
		return result;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_key = '0;
			slow_key = '0;
			decrypt = DIR_ENCRYPT;
			fast_shift = '0;
			slow_shift = '0;
			letters_since_turn = 0;
			middle_turns = 0;
			cipher_queue.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KEY_FAST:  fast_key = cfg_data;
					REG_KEY_SLOW:  slow_key = cfg_data;
					REG_DIRECTION: decrypt = cfg_data[0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (cipher_queue.size() == 0) begin
					$error("letter_out: expected none, actual %0d", m_tdata[4:0]);
					fail_count++;
				end else begin
					want = cipher_queue.pop_front();
					if (m_tdata[4:0] !== want) begin
						$error("letter_out: expected %0d, actual %0d", want, m_tdata[4:0]);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				cipher_queue.push_back(cipher_letter(s_tdata[4:0], s_tuser));
			end
			pending = cipher_queue.size();
		end
	end

endmodule

FILE: tb/sv/three_rotor_substitution_cipher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_rotor_substitution_cipher_tb
// drives directed and random letter streams through the rotor cipher under
// several key and direction settings, with random stalls on both sides;
// the checker predicts every output letter and counts mismatches
// ----------------------------------------------------------------------------
module three_rotor_substitution_cipher_tb;

	import trsc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	letter_t              cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;   // letter_in [4:0], zero pad
	logic                 s_tuser;   // restart
	logic                 m_tvalid;
	logic                 m_tready;
	logic [7:0]           m_tdata;   // letter_out [4:0], zero pad

	int src_idle = 0;
	int snk_idle = 0;
	int cycles = 0;
	int fail_count;
	int pending;

	three_rotor_substitution_cipher uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	three_rotor_substitution_cipher_checker cipher_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("three_rotor_substitution_cipher regression: fail");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle);
		end
	end

	// wait until every letter in flight has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input letter_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_rotors(input letter_t fast_key, input letter_t slow_key,
			input letter_t dir_code);
		drain();
		write_reg(REG_KEY_FAST, fast_key);
		write_reg(REG_KEY_SLOW, slow_key);
		write_reg(REG_DIRECTION, dir_code);
		write_reg(REG_UNUSED, letter_t'($urandom_range(31)));
		cfg_valid <= 1'b0;
	endtask

	task automatic send_letter(input letter_t letter, input logic restart);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, letter};
		s_tuser <= restart;
		do @(posedge clk); while (!s_tready);
	endtask

	// mostly valid letters, a few codes past the alphabet
	function automatic letter_t random_letter();
		if ($urandom_range(99) < 6) begin
			return letter_t'($urandom_range(31, 26));
		end
		return letter_t'($urandom_range(25));
	endfunction

	function automatic letter_t random_key();
		if ($urandom_range(99) < 15) begin
			return letter_t'($urandom_range(31, 26));
		end
		return letter_t'($urandom_range(25));
	endfunction

	// a message usually opens with a restart; stray restarts inside act as noise
	task automatic random_message(input int len);
		for (int i = 0; i < len; i++) begin
			if (i == 0) begin
				send_letter(random_letter(), $urandom_range(99) < 90);
			end else begin
				send_letter(random_letter(), $urandom_range(99) < 2);
			end
		end
	endtask

	initial begin
		int sent;
		int len;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// rotors straight out of reset, no restart
		send_letter(5'd0, 1'b0);
		send_letter(LAST_LETTER, 1'b0);
		send_letter(5'd26, 1'b0);
		send_letter(5'd31, 1'b0);

		program_rotors(5'd0, 5'd0, {4'b0000, DIR_ENCRYPT});
		send_letter(5'd0, 1'b1);
		send_letter(LAST_LETTER, 1'b0);
		send_letter(5'd13, 1'b0);

		// slow key past the alphabet, direction upper bits set
		program_rotors(LAST_LETTER, 5'd31, {4'b1111, DIR_ENCRYPT});
		send_letter(5'd31, 1'b1);
		send_letter(5'd7, 1'b0);
		send_letter(LAST_LETTER, 1'b0);

		program_rotors(5'd31, LAST_LETTER, {4'b0000, ~DIR_ENCRYPT});
		send_letter(5'd0, 1'b1);
		send_letter(LAST_LETTER, 1'b0);
		send_letter(5'd26, 1'b0);
		send_letter(5'd12, 1'b0);

		program_rotors(5'd13, 5'd7, {4'b1111, ~DIR_ENCRYPT});
		send_letter(5'd5, 1'b1);
		send_letter(5'd30, 1'b1);
		send_letter(5'd21, 1'b0);

		for (int phase = 0; phase < 3; phase++) begin
			src_idle = (phase == 0) ? 27 : (phase == 1) ? 45 : 0;
			snk_idle = (phase == 0) ? 45 : (phase == 1) ? 27 : 0;
			repeat (3) begin
				program_rotors(random_key(), random_key(), letter_t'($urandom_range(31)));
				sent = 0;
				while (sent < 25) begin
					len = $urandom_range(40, 1);
					random_message(len);
					sent += len;
				end
			end
		end

		// one long message across several middle counter turns
		program_rotors(random_key(), random_key(), letter_t'($urandom_range(31)));
		send_letter(random_letter(), 1'b1);
		repeat (120) send_letter(random_letter(), 1'b0);

		drain();
		if (fail_count == 0) begin
			$display("three_rotor_substitution_cipher regression: pass");
		end else begin
			$display("three_rotor_substitution_cipher regression: fail");
		end
		$finish;
	end

endmodule
